// ----- rtl/hclp_pkg.sv -----
// hclp_pkg: shared types, character codes and the hex digit function
// for the hex color line parser; no dependencies
`timescale 1ns / 1ps

package hclp_pkg;

    // line editing characters
    localparam logic [7:0] CH_DEL  = 8'd127;
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_HASH = 8'd35;

    // digit ranges
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_NINE = 8'd57;
    localparam logic [7:0] CH_A    = 8'd65;
    localparam logic [7:0] CH_F    = 8'd70;

    // stored prefix of the line: '#' plus six digits
    localparam int STORE_DEPTH = 7;

    // default saturation length of the line
    localparam int LINE_MAX_DEF = 64;

    typedef logic [7:0] char_t;
    typedef logic [STORE_DEPTH-1:0][7:0] line_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_FORM  = 2'd1,
        ST_BAD_DIGIT = 2'd2
    } status_t;

    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } digit_t;

    // uppercase hex digit decode; bad set for anything else
    function automatic digit_t hex_digit(input char_t c);
        digit_t d;
        d.bad   = 1'b1;
        d.value = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d.bad   = 1'b0;
            d.value = c[3:0];
        end
        else if (c >= CH_A && c <= CH_F)
        begin
            d.bad   = 1'b0;
            d.value = c[3:0] + 4'd9;
        end
        return d;
    endfunction

endpackage

// ----- rtl/hclp_decode.sv -----
// hclp_decode: checks a finished line and turns '#RRGGBB' into color bytes
// depends on hclp_pkg
`timescale 1ns / 1ps

module hclp_decode
    import hclp_pkg::*;
#(
    parameter int LEN_W = 7
)
(
    input  line_t            line,
    input  logic [LEN_W-1:0] length,
    output status_t          status,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue
);

    digit_t [5:0] digits;
    logic         any_bad;
    logic         form_ok;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            digits[i] = hex_digit(line[i+1]);
        end
    end

    assign any_bad = digits[0].bad | digits[1].bad | digits[2].bad
                   | digits[3].bad | digits[4].bad | digits[5].bad;
    assign form_ok = (length == LEN_W'(STORE_DEPTH)) && (line[0] == CH_HASH);

    always_comb
    begin
        status = ST_OK;
        red    = 8'd0;
        green  = 8'd0;
        blue   = 8'd0;
        if (!form_ok)
        begin
            status = ST_BAD_FORM;
        end
        else if (any_bad)
        begin
            status = ST_BAD_DIGIT;
        end
        else
        begin
            red   = {digits[0].value, digits[1].value};
            green = {digits[2].value, digits[3].value};
            blue  = {digits[4].value, digits[5].value};
        end
    end

endmodule

// ----- rtl/hex_color_line_parser_top.sv -----
// hex_color_line_parser_top: line editor and '#RRGGBB' color parser
// depends on hclp_pkg and hclp_decode
`timescale 1ns / 1ps

// usage
//   input channel: one received character per transaction on rx_char,
//   taken at a rising edge with in_valid high and in_stall low
//   delete (127) drops the last character, carriage return ends the line,
//   anything else is appended; the length saturates at LINE_MAX and only
//   the first seven characters are kept
//   output channel: one transaction per carriage return carrying status,
//   red, green and blue, taken when out_valid is high and out_stall low;
//   colors are zero whenever status is not ok
// pipeline and throughput
//   a character is registered at its accept edge and processed from the
//   input register; the result of a carriage return is registered when it
//   is processed; one character per cycle is sustained while in_stall is low,
//   set by the single input register feeding line state and result register
// reset: rst_n low clears the line length and both valid flags; stored
//   characters are not cleared and are only read when all seven are written
// stall
//   while a result is held by out_stall, characters that give no result
//   keep flowing; a carriage return waits in the input register and
//   in_stall rises until the output register frees up

module hex_color_line_parser_top
    import hclp_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);

    // length counter must hold LINE_MAX itself
    localparam int LEN_W = $clog2(LINE_MAX + 1);

    // input stage
    logic             s1_valid_reg;
    logic             s1_valid_next;
    char_t            s1_char_reg;

    // line state
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    line_t            line_reg;

    // result register
    logic             out_valid_reg;
    logic             out_valid_next;
    status_t          status_reg;
    logic [7:0]       red_reg;
    logic [7:0]       green_reg;
    logic [7:0]       blue_reg;

    // processing controls
    logic             is_del;
    logic             is_cr;
    logic             out_free;
    logic             s1_adv;
    logic             in_take;
    logic             wr_en;

    status_t          dec_status;
    logic [7:0]       dec_red;
    logic [7:0]       dec_green;
    logic [7:0]       dec_blue;

    assign is_del   = (s1_char_reg == CH_DEL);
    assign is_cr    = (s1_char_reg == CH_CR);
    // output register can take a new result this cycle
    assign out_free = !out_valid_reg || !out_stall;
    // the buffered character is processed unless it is a held-up line end
    assign s1_adv   = s1_valid_reg && (!is_cr || out_free);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    // append only while below the saturation length
    assign wr_en    = s1_adv && !is_del && !is_cr && (len_reg < LEN_W'(LINE_MAX));

    assign s1_valid_next = in_take || (s1_valid_reg && !s1_adv);

    always_comb
    begin
        len_next = len_reg;
        if (s1_adv)
        begin
            if (is_del)
            begin
                if (len_reg != '0)
                begin
                    len_next = len_reg - LEN_W'(1);
                end
            end
            else if (is_cr)
            begin
                len_next = '0;
            end
            else if (wr_en)
            begin
                len_next = len_reg + LEN_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (s1_adv && is_cr)
        begin
            out_valid_next = 1'b1;
        end
    end

    hclp_decode #(
        .LEN_W (LEN_W)
    ) u_decode (
        .line   (line_reg),
        .length (len_reg),
        .status (dec_status),
        .red    (dec_red),
        .green  (dec_green),
        .blue   (dec_blue)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_char_reg <= rx_char;
        end
    end

    // stored prefix, one register per position
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (wr_en && (len_reg == LEN_W'(i)))
            begin
                line_reg[i] <= s1_char_reg;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (s1_adv && is_cr)
        begin
            status_reg <= dec_status;
            red_reg    <= dec_red;
            green_reg  <= dec_green;
            blue_reg   <= dec_blue;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

`ifndef SYNTHESIS
    // length never passes the saturation point
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(LINE_MAX))
        else $error("line length above LINE_MAX");

    // a processed line end always leaves an empty line
    a_cr_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && is_cr) |=> (len_reg == '0))
        else $error("line not cleared after line end");

    // a rejected line carries no color
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_OK)) |->
        (red_reg == 8'd0 && green_reg == 8'd0 && blue_reg == 8'd0))
        else $error("nonzero color on error status");

    // a line end is held back only by a stalled full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && is_cr && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");
`endif

endmodule
